@@ rtl/core/mmtt_pkg.sv @@
// ----------------------------------------------------------------------------
// mmtt_pkg
// Types and constants shared by the min/max tracking table.
// ----------------------------------------------------------------------------
package mmtt_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_RESCAN,
      ST_DONE
   } state_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic              valid;
      logic signed [31:0] value;
   } entry_type;

   localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] EMPTY_MAX = 32'sh8000_0000;

endpackage

@@ rtl/core/min_max_tracking_table_core.sv @@
// ----------------------------------------------------------------------------
// min_max_tracking_table_core
// Multiset of signed 32-bit values in a table of ENTRIES slots with a
// running minimum and maximum.
// ----------------------------------------------------------------------------
// Each request inserts a value into the first free slot or deletes one
// occurrence (lowest slot that matches); each gives one response with the
// status, the minimum, the maximum and the count held afterwards. The table
// is one single-port-read memory walked one slot per cycle by a single
// compare unit. After reset a clearing pass writes every slot before the
// first request is taken. An insert into a full table skips the search;
// any other insert or a delete searches from the first slot and stops at
// the first hit, and a delete that removes the current minimum or maximum
// adds a full rescan of the table. One request is handled at a time; a new
// request is taken while the previous response still waits.
module min_max_tracking_table_core
   import mmtt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_min_value,
   output logic signed [31:0] rsp_max_value,
   output logic [4:0]         rsp_count
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

   entry_type entry_mem [ENTRIES];

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               issue_ff, issue_in;
   logic               rvalid_ff, rvalid_in;
   logic [IDX_W-1:0]   ridx_ff;
   entry_type          rd_entry_ff;
   op_type             op_ff, op_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] min_ff, min_in;
   logic signed [31:0] max_ff, max_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic signed [31:0] rsp_min_ff, rsp_max_ff;
   logic [4:0]         rsp_count_ff;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;
   logic               flush;
   logic               req_fire;
   logic               rsp_load;
   logic               full;
   logic               search_hit;
   logic               scan_last;
   logic               need_rescan;
   logic [31:0]        count_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign full      = (count_ff == FULL_CNT);
   assign scan_last = rvalid_ff && (ridx_ff == LAST_IDX);
   assign need_rescan = (val_ff == min_ff) || (val_ff == max_ff);

   always_comb begin
      if (op_ff == OP_INSERT) begin
         search_hit = rvalid_ff && !rd_entry_ff.valid;
      end else begin
         search_hit = rvalid_ff && rd_entry_ff.valid && (rd_entry_ff.value == val_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (op_type'(req_func) == OP_INSERT && full) state_in = ST_DONE;
               else state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (search_hit) begin
               if (op_ff == OP_DELETE && need_rescan) state_in = ST_RESCAN;
               else state_in = ST_DONE;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_RESCAN: begin
            if (scan_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      addr_in   = addr_ff;
      issue_in  = issue_ff;
      flush     = 1'b0;
      op_in     = op_ff;
      val_in    = val_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      count_in  = count_ff;
      status_in = status_ff;

      // The read address walks forward while a scan is issuing reads.
      if (issue_ff) begin
         addr_in = addr_ff + IDX_W'(1);
         if (addr_ff == LAST_IDX) issue_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = op_type'(req_func);
               val_in = req_value;
               if (op_type'(req_func) == OP_INSERT && full) begin
                  status_in = STATUS_FULL;
               end else begin
                  addr_in  = '0;
                  issue_in = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (search_hit) begin
               flush           = 1'b1;
               issue_in        = 1'b0;
               status_in       = STATUS_OK;
               mem_we          = 1'b1;
               mem_waddr       = ridx_ff;
               mem_wdata.valid = (op_ff == OP_INSERT);
               mem_wdata.value = val_ff;
               if (op_ff == OP_INSERT) begin
                  count_in = count_ff + CNT_W'(1);
                  if (val_ff < min_ff) min_in = val_ff;
                  if (val_ff > max_ff) max_in = val_ff;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  if (need_rescan) begin
                     // Start over from the first slot with the empty bounds.
                     min_in   = EMPTY_MIN;
                     max_in   = EMPTY_MAX;
                     addr_in  = '0;
                     issue_in = 1'b1;
                  end
               end
            end else if (scan_last) begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         ST_RESCAN: begin
            if (rvalid_ff && rd_entry_ff.valid) begin
               if (rd_entry_ff.value < min_ff) min_in = rd_entry_ff.value;
               if (rd_entry_ff.value > max_ff) max_in = rd_entry_ff.value;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase

      rvalid_in = issue_ff && !flush;
   end

   assign count_ext    = {{(32 - CNT_W){1'b0}}, count_ff};
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // Table memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
      rd_entry_ff <= entry_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         issue_ff     <= 1'b0;
         rvalid_ff    <= 1'b0;
         min_ff       <= EMPTY_MIN;
         max_ff       <= EMPTY_MAX;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         issue_ff     <= issue_in;
         rvalid_ff    <= rvalid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff   <= addr_ff;
      op_ff     <= op_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_min_ff    <= min_ff;
         rsp_max_ff    <= max_ff;
         rsp_count_ff  <= count_ext[4:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_count     = rsp_count_ff;

endmodule
